FILE: rtl/core/gnal_pkg.sv
// shared types, constants and config decoding for the grid neighbor address list
package gnal_pkg;

  localparam int unsigned MAX_RANK = 3;
  localparam int unsigned MAX_DIM  = 1024;
  localparam int unsigned CW       = 10;
  localparam int unsigned DW       = 11;
  localparam int unsigned AW       = 30;
  localparam int unsigned CODE_W   = 6;
  localparam int unsigned IDX_W    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_RANK      = 3'd0,
    REG_MODE      = 3'd1,
    REG_DIM_0     = 3'd2,
    REG_DIM_1     = 3'd3,
    REG_DIM_2     = 3'd4,
    REG_WRAP_MASK = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_NEIGHBOR = 2'd0,
    ST_NONE     = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  localparam logic [2:0] MODE_FACE      = 3'd0;
  localparam logic [2:0] MODE_FACE_PER  = 3'd1;
  localparam logic [2:0] MODE_BOX       = 3'd2;
  localparam logic [2:0] MODE_BOX_PER   = 3'd3;
  localparam logic [2:0] MODE_FACE_MASK = 3'd4;
  localparam logic [2:0] MODE_BOX_MASK  = 3'd5;
  localparam logic [2:0] MODE_FACE_CODE = 3'd6;
  localparam logic [2:0] MODE_BOX_CODE  = 3'd7;

  // raw register contents
  typedef struct packed {
    logic [1:0]    rank;
    logic [2:0]    mode;
    logic [DW-1:0] dim_0;
    logic [DW-1:0] dim_1;
    logic [DW-1:0] dim_2;
    logic [2:0]    wrap_mask;
  } cfg_t;

  // clamped geometry and mode flags
  typedef struct packed {
    logic [1:0]             rank;
    logic [2:0][DW-1:0]     dim;
    logic                   face;
    logic                   dedup;
    logic                   codes;
    logic [2:0]             per;
  } geom_t;

  // one classified cell handed from front to back
  typedef struct packed {
    logic               err;
    logic [2:0][CW-1:0] coord;
    logic [AW-1:0]      ad;
    logic [AW-1:0]      s0;
    logic [AW-1:0]      w0;
    logic [AW-1:0]      w1;
  } item_t;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
    clamp_dim = (d > DW'(MAX_DIM)) ? DW'(MAX_DIM) : d;
  endfunction

  function automatic geom_t decode_cfg(input cfg_t c);
    geom_t g;
    g.rank = (c.rank == 2'd0) ? 2'd1 : c.rank;
    if (g.rank > 2'(MAX_RANK)) g.rank = 2'(MAX_RANK);
    g.dim[0] = clamp_dim(c.dim_0);
    g.dim[1] = clamp_dim(c.dim_1);
    g.dim[2] = clamp_dim(c.dim_2);
    g.face   = (c.mode == MODE_FACE) || (c.mode == MODE_FACE_PER) ||
               (c.mode == MODE_FACE_MASK) || (c.mode == MODE_FACE_CODE);
    g.dedup  = (c.mode == MODE_FACE_PER) || (c.mode == MODE_BOX_PER) ||
               (c.mode == MODE_FACE_MASK) || (c.mode == MODE_BOX_MASK);
    g.codes  = (c.mode == MODE_FACE_CODE) || (c.mode == MODE_BOX_CODE);
    if ((c.mode == MODE_FACE_PER) || (c.mode == MODE_BOX_PER)) g.per = 3'b111;
    else if (c.mode >= MODE_FACE_MASK) g.per = c.wrap_mask;
    else g.per = 3'b000;
    return g;
  endfunction

endpackage

FILE: rtl/core/gnal_in_if.sv
// input channel carrying one cell coordinate word
interface gnal_in_if import gnal_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] coord_0;
  logic [CW-1:0] coord_1;
  logic [CW-1:0] coord_2;
  modport source(output valid, output coord_0, output coord_1, output coord_2, input ready);
  modport sink(input valid, input coord_0, input coord_1, input coord_2, output ready);
endinterface

FILE: rtl/core/gnal_out_if.sv
// output channel carrying one neighbor result word
interface gnal_out_if import gnal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AW-1:0]     neighbor_address;
  logic [CODE_W-1:0] wrap_code;
  logic              after_center;
  logic [1:0]        status;
  logic              last;
  modport source(output valid, output neighbor_address, output wrap_code,
                 output after_center, output status, output last, input ready);
  modport sink(input valid, input neighbor_address, input wrap_code,
               input after_center, input status, input last, output ready);
endinterface

FILE: rtl/core/gnal_cfg_if.sv
// configuration write channel
interface gnal_cfg_if import gnal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [DW-1:0]    data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/gnal_front.sv
// front end: accepts a cell, checks range, computes center address, strides and wrap deltas
module gnal_front import gnal_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  geom_t       geom_i,
  gnal_in_if.sink     in_i,
  output logic        push_valid_o,
  output item_t       push_item_o,
  input  logic        push_ready_i
);

  typedef enum logic [2:0] {
    F_IDLE, F_CENTER_A, F_CENTER_B, F_STRIDE, F_WRAP_0, F_WRAP_1, F_PUSH
  } fstate_e;

  fstate_e            state_q;
  logic [2:0][CW-1:0] c_q;
  logic               err_q;
  logic [20:0]        acc_q;
  logic [AW-1:0]      ad_q, s0_q, w0_q, w1_q;

  logic [2:0][CW-1:0] in_c;
  logic [2:0][CW-1:0] ce;
  logic [DW-1:0]      d0, d1, d2;
  logic               range_err;
  logic [20:0]        mul_a;
  logic [DW-1:0]      mul_b;
  logic [CW-1:0]      mul_c;
  logic [31:0]        prod;

  assign in_c[0] = in_i.coord_0;
  assign in_c[1] = in_i.coord_1;
  assign in_c[2] = in_i.coord_2;

  // range check over the used dimensions
  always_comb begin
    range_err = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) < geom_i.rank) && ({1'b0, in_c[i]} >= geom_i.dim[i])) range_err = 1'b1;
    end
  end

  // unused dimensions act as size one, coordinate zero
  always_comb begin
    d0 = geom_i.dim[0];
    d1 = (geom_i.rank >= 2'd2) ? geom_i.dim[1] : DW'(1);
    d2 = (geom_i.rank >= 2'd3) ? geom_i.dim[2] : DW'(1);
    ce[0] = c_q[0];
    ce[1] = (geom_i.rank >= 2'd2) ? c_q[1] : '0;
    ce[2] = (geom_i.rank >= 2'd3) ? c_q[2] : '0;
  end

  // shared multiply-add, one product per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    unique case (state_q)
      F_CENTER_A: begin mul_a = 21'(ce[0]); mul_b = d1; mul_c = ce[1]; end
      F_CENTER_B: begin mul_a = acc_q; mul_b = d2; mul_c = ce[2]; end
      F_STRIDE:   begin mul_a = 21'(d1); mul_b = d2; end
      F_WRAP_0:   begin mul_a = s0_q[20:0]; mul_b = d0 - DW'(1); end
      F_WRAP_1:   begin mul_a = 21'(d2); mul_b = d1 - DW'(1); end
      default:    begin mul_a = '0; end
    endcase
  end

  assign prod = 32'(mul_a) * 32'(mul_b) + 32'(mul_c);

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_i.valid) begin
            c_q     <= in_c;
            err_q   <= range_err;
            state_q <= range_err ? F_PUSH : F_CENTER_A;
          end
        end
        F_CENTER_A: begin acc_q <= prod[20:0]; state_q <= F_CENTER_B; end
        F_CENTER_B: begin ad_q <= prod[AW-1:0]; state_q <= F_STRIDE; end
        F_STRIDE:   begin s0_q <= prod[AW-1:0]; state_q <= F_WRAP_0; end
        F_WRAP_0:   begin w0_q <= prod[AW-1:0]; state_q <= F_WRAP_1; end
        F_WRAP_1:   begin w1_q <= prod[AW-1:0]; state_q <= F_PUSH; end
        F_PUSH: begin
          if (push_ready_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign in_i.ready   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);

  always_comb begin
    push_item_o.err   = err_q;
    push_item_o.coord = c_q;
    push_item_o.ad    = ad_q;
    push_item_o.s0    = s0_q;
    push_item_o.w0    = w0_q;
    push_item_o.w1    = w1_q;
  end

endmodule

FILE: rtl/core/gnal_queue.sv
// two-entry queue between front and back
module gnal_queue import gnal_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  item_t push_item_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_ready_i
);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_item_i;
  end

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

FILE: rtl/core/gnal_back.sv
// back end: walks neighbor offsets, drops duplicates in dedup modes, emits results
module gnal_back import gnal_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 26
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  geom_t       geom_i,
  input  logic        pop_valid_i,
  input  item_t       pop_item_i,
  output logic        pop_ready_o,
  gnal_out_if.source  out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned SIX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

  typedef enum logic [1:0] {G_IDLE, G_RUN, G_END} gstate_e;

  typedef struct packed {
    logic              is_end;
    logic              err;
    logic [AW-1:0]     addr;
    logic [CODE_W-1:0] code;
    logic              after;
  } cand_t;

  // walker state
  gstate_e        gst_q;
  item_t          it_q;
  logic [2:0][1:0] dg_q;
  logic [2:0]     fk_q;
  logic           aft_q;

  // candidate stage
  logic           cand_vq;
  cand_t          cand_q;

  // pending result and output register
  logic           pend_vq;
  cand_t          pend_q;
  logic           out_vq;
  logic [AW-1:0]  out_addr_q;
  logic [CODE_W-1:0] out_code_q;
  logic           out_after_q;
  status_e        out_status_q;
  logic           out_last_q;

  // emitted address store
  logic [AW-1:0]  store_q [MAX_NEIGHBORS];
  logic [CNT_W-1:0] cnt_q;

  logic [2:0][1:0] pd;
  logic [2:0][1:0] dg_next;
  logic [1:0]     fdim;
  logic [2:0]     two_r;
  logic           center, lastpos, ok;
  logic [AW-1:0]  addr;
  logic [CODE_W-1:0] code;
  logic           after;
  logic           cand_rdy, eval_take, need_push, can_push, hit, keep;

  assign two_r = {geom_i.rank, 1'b0};
  assign fdim  = 2'(two_r - 3'd1 - fk_q);

  // current offset digits, next digits and end of walk
  always_comb begin
    logic carry;
    pd = dg_q;
    if (geom_i.face) begin
      pd = {3{2'd1}};
      if (fk_q < {1'b0, geom_i.rank}) pd[fk_q[1:0]] = 2'd0;
      else pd[fdim] = 2'd2;
    end
    center = !geom_i.face && (pd == {3{2'd1}});
    if (geom_i.face) begin
      lastpos = (fk_q == two_r - 3'd1);
    end else begin
      lastpos = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if ((2'(i) < geom_i.rank) && (pd[i] != 2'd2)) lastpos = 1'b0;
      end
    end
    dg_next = dg_q;
    carry = 1'b1;
    for (int i = 2; i >= 0; i--) begin
      if ((2'(i) < geom_i.rank) && carry) begin
        if (dg_q[i] == 2'd2) begin
          dg_next[i] = 2'd0;
        end else begin
          dg_next[i] = dg_q[i] + 2'd1;
          carry = 1'b0;
        end
      end
    end
  end

  // neighbor address from center address plus per-dimension deltas
  always_comb begin
    logic [2:0][AW-1:0] sd, wd, dl;
    logic [DW-1:0] d2e;
    d2e = (geom_i.rank >= 2'd3) ? geom_i.dim[2] : DW'(1);
    sd[0] = it_q.s0;
    sd[1] = AW'(d2e);
    sd[2] = AW'(1);
    wd[0] = it_q.w0;
    wd[1] = it_q.w1;
    wd[2] = AW'(d2e - DW'(1));
    ok   = 1'b1;
    code = '0;
    for (int i = 0; i < 3; i++) begin
      dl[i] = '0;
      if (2'(i) < geom_i.rank) begin
        if (pd[i] == 2'd0) begin
          if (it_q.coord[i] != '0) dl[i] = AW'(0) - sd[i];
          else if (geom_i.per[i]) begin
            dl[i] = wd[i];
            code[2*i +: 2] = 2'd1;
          end else ok = 1'b0;
        end else if (pd[i] == 2'd2) begin
          if (({1'b0, it_q.coord[i]} + DW'(1)) < geom_i.dim[i]) dl[i] = sd[i];
          else if (geom_i.per[i]) begin
            dl[i] = AW'(0) - wd[i];
            code[2*i +: 2] = 2'd2;
          end else ok = 1'b0;
        end
      end
    end
    if (!geom_i.codes) code = '0;
    addr  = it_q.ad + dl[0] + dl[1] + dl[2];
    after = geom_i.face ? (fk_q >= {1'b0, geom_i.rank}) : aft_q;
  end

  // duplicate search over the emitted store
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < MAX_NEIGHBORS; k++) begin
      if ((CNT_W'(k) < cnt_q) && (store_q[k] == cand_q.addr)) hit = 1'b1;
    end
  end

  // result stage handshake
  assign can_push  = !out_vq || out_o.ready;
  assign keep      = !(geom_i.dedup && hit) && (cnt_q < CNT_W'(MAX_NEIGHBORS));
  assign need_push = cand_q.is_end || (keep && pend_vq);
  assign eval_take = cand_vq && !(need_push && !can_push);
  assign cand_rdy  = !cand_vq || eval_take;
  assign pop_ready_o = (gst_q == G_IDLE);

  // offset walker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gst_q   <= G_IDLE;
      cand_vq <= 1'b0;
    end else begin
      if (eval_take) cand_vq <= 1'b0;
      unique case (gst_q)
        G_IDLE: begin
          if (pop_valid_i) begin
            it_q  <= pop_item_i;
            fk_q  <= 3'd0;
            aft_q <= 1'b0;
            for (int i = 0; i < 3; i++) dg_q[i] <= (2'(i) < geom_i.rank) ? 2'd0 : 2'd1;
            gst_q <= pop_item_i.err ? G_END : G_RUN;
          end
        end
        G_RUN: begin
          if (cand_rdy) begin
            if (center) begin
              aft_q <= 1'b1;
            end else if (ok) begin
              cand_vq       <= 1'b1;
              cand_q.is_end <= 1'b0;
              cand_q.err    <= 1'b0;
              cand_q.addr   <= addr;
              cand_q.code   <= code;
              cand_q.after  <= after;
            end
            fk_q <= fk_q + 3'd1;
            dg_q <= dg_next;
            if (lastpos) gst_q <= G_END;
          end
        end
        G_END: begin
          if (cand_rdy) begin
            cand_vq       <= 1'b1;
            cand_q.is_end <= 1'b1;
            cand_q.err    <= it_q.err;
            cand_q.addr   <= '0;
            cand_q.code   <= '0;
            cand_q.after  <= 1'b0;
            gst_q         <= G_IDLE;
          end
        end
        default: gst_q <= G_IDLE;
      endcase
    end
  end

  // store writes
  always_ff @(posedge clk_i) begin
    if (eval_take && !cand_q.is_end && keep) store_q[cnt_q[SIX_W-1:0]] <= cand_q.addr;
  end

  // pending result, count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vq <= 1'b0;
      cnt_q   <= '0;
      out_vq  <= 1'b0;
    end else begin
      if (out_o.ready) out_vq <= 1'b0;
      if (eval_take) begin
        if (cand_q.is_end) begin
          out_vq <= 1'b1;
          out_last_q <= 1'b1;
          if (cand_q.err) begin
            out_addr_q <= '0; out_code_q <= '0; out_after_q <= 1'b0;
            out_status_q <= ST_RANGE;
          end else if (pend_vq) begin
            out_addr_q <= pend_q.addr; out_code_q <= pend_q.code;
            out_after_q <= pend_q.after; out_status_q <= ST_NEIGHBOR;
          end else begin
            out_addr_q <= '0; out_code_q <= '0; out_after_q <= 1'b0;
            out_status_q <= ST_NONE;
          end
          pend_vq <= 1'b0;
          cnt_q   <= '0;
        end else if (keep) begin
          if (pend_vq) begin
            out_vq <= 1'b1;
            out_last_q <= 1'b0;
            out_addr_q <= pend_q.addr; out_code_q <= pend_q.code;
            out_after_q <= pend_q.after; out_status_q <= ST_NEIGHBOR;
          end
          pend_q  <= cand_q;
          pend_vq <= 1'b1;
          cnt_q   <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  assign out_o.valid            = out_vq;
  assign out_o.neighbor_address = out_addr_q;
  assign out_o.wrap_code        = out_code_q;
  assign out_o.after_center     = out_after_q;
  assign out_o.status           = out_status_q;
  assign out_o.last             = out_last_q;

endmodule

FILE: rtl/core/grid_neighbor_address_list.sv
// Grid neighbor address list: a cell in, its neighbor addresses out, one word per cycle
// at most, held while the output is not ready. The front holds a cell through accept,
// five shared multiply steps and push; an out-of-range cell skips the multiply steps.
// The back walks one offset per cycle when the output does not stall it: 2*rank offsets
// in face modes, 3^rank in box modes; meanwhile the front can take the next cell.
// Reset: registers return to rank 3, mode 0, sizes 16, no wrap; queue and output empty.
module grid_neighbor_address_list import gnal_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 26
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gnal_cfg_if.sink    cfg_i,
  gnal_in_if.sink     in_i,
  gnal_out_if.source  out_o
);

  cfg_t  cfg_q;
  geom_t geom;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rank      <= 2'd3;
      cfg_q.mode      <= MODE_FACE;
      cfg_q.dim_0     <= DW'(16);
      cfg_q.dim_1     <= DW'(16);
      cfg_q.dim_2     <= DW'(16);
      cfg_q.wrap_mask <= 3'd0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RANK:      cfg_q.rank      <= cfg_i.data[1:0];
        REG_MODE:      cfg_q.mode      <= cfg_i.data[2:0];
        REG_DIM_0:     cfg_q.dim_0     <= cfg_i.data;
        REG_DIM_1:     cfg_q.dim_1     <= cfg_i.data;
        REG_DIM_2:     cfg_q.dim_2     <= cfg_i.data;
        REG_WRAP_MASK: cfg_q.wrap_mask <= cfg_i.data[2:0];
        default:       cfg_q.rank      <= cfg_q.rank;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;
  assign geom        = decode_cfg(cfg_q);

  gnal_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  gnal_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  gnal_back #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
